@@ hdl/hex_fragment_reassembler_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the hex fragment reassembler.
// ----------------------------------------------------------------------------
`ifndef HEX_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH
`define HEX_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define HFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The expression must never be true outside reset.
`define HFR_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`else

`define HFR_ASSERT(label, prop, msg)
`define HFR_ASSERT_NEVER(label, expr, msg)

`endif

`endif

@@ hdl/hfr_pkg.sv @@
// ----------------------------------------------------------------------------
// hfr_pkg
// Types, constants and decode helpers of the hex fragment reassembler.
// ----------------------------------------------------------------------------
package hfr_pkg;

  localparam int unsigned BufferBytes = 256;
  localparam int unsigned MaxPieces   = 6;
  localparam logic [6:0]  StrideReset = 7'd43;

  // Result kinds.
  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_MORE     = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_REJECT   = 2'd3;

  // Parser phases.
  localparam logic [2:0] PH_HDR_SEQ   = 3'd0;
  localparam logic [2:0] PH_HDR_PIECE = 3'd1;
  localparam logic [2:0] PH_HDR_COUNT = 3'd2;
  localparam logic [2:0] PH_HIGH      = 3'd3;
  localparam logic [2:0] PH_LOW       = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [8:0] position;
    logic       peer_type;
    logic [2:0] sequence_res;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hdl/hex_fragment_reassembler_top.sv @@
// ----------------------------------------------------------------------------
// hex_fragment_reassembler_top
// Decodes text fragments into byte writes and one status per fragment.
// ----------------------------------------------------------------------------
// The block takes one character per beat, every cycle that in_stall_o is
// low. A character sits in an input register until the queue has room, is
// decoded against the parser state, and its results (a byte write, a
// fragment status, or both when the final character completes a byte) go
// into a four-entry result queue that drives the output one result per beat
// while out_stall_i is low. A result passes the input register and the queue
// before it reaches the output. The input stalls while more than two results
// are queued and a character is held, so the sustained rate is one character
// per cycle as long as the output keeps pace with the results produced.
`include "hex_fragment_reassembler_top_macros.svh"

module hex_fragment_reassembler_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_fragment_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic [8:0] position_o,
  output logic       peer_type_o,
  output logic [2:0] sequence_res_o,
  output logic       last_o
);

  localparam logic [8:0] BufLimit = 9'(hfr_pkg::BufferBytes);

  logic [6:0] stride_q;

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic       s1_eof_q;
  logic       in_accept, s1_advance;

  // Parser state.
  logic [2:0] phase_q, phase_d;
  logic [3:0] high_nib_q, high_nib_d;
  logic       high_hex_q, high_hex_d;
  logic       peer_q, peer_d;
  logic [2:0] seq_q, seq_d;
  logic [2:0] piece_q, piece_d;
  logic [2:0] total_q, total_d;
  logic [8:0] woff_q, woff_d;
  logic       rej_q, rej_d;

  // Result queue.
  hfr_pkg::result_t fifo_q [4];
  logic [1:0] head_q, tail_q;
  logic [2:0] count_q;
  logic       room, pop;
  logic       push_wr, push_st;
  hfr_pkg::result_t wr_res, st_res;

  hfr_pkg::hex_t hx;
  logic [9:0]    start;

  assign room       = count_q <= 3'd2;
  assign s1_advance = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    high_nib_d = high_nib_q;
    high_hex_d = high_hex_q;
    peer_d     = peer_q;
    seq_d      = seq_q;
    piece_d    = piece_q;
    total_d    = total_q;
    woff_d     = woff_q;
    rej_d      = rej_q;
    push_wr    = 1'b0;
    hx         = hfr_pkg::hex_decode(s1_char_q);
    start      = {7'd0, piece_q} * {3'd0, stride_q};

    wr_res              = '0;
    wr_res.kind         = hfr_pkg::KIND_WRITE;
    wr_res.data_byte    = {high_nib_q, hx.value};
    wr_res.position     = woff_q;
    wr_res.peer_type    = peer_q;
    wr_res.sequence_res = seq_q;
    wr_res.last         = !s1_eof_q;

    if (!rej_q) begin
      case (phase_q)
        hfr_pkg::PH_HDR_SEQ: begin
          if (s1_char_q >= 8'h30 && s1_char_q <= 8'h37) begin
            peer_d = 1'b0;
            seq_d  = 3'(s1_char_q - 8'h30);
          end else if (s1_char_q >= 8'h41 && s1_char_q <= 8'h48) begin
            peer_d = 1'b1;
            seq_d  = 3'(s1_char_q - 8'h41);
          end else begin
            rej_d = 1'b1;
          end
          phase_d = hfr_pkg::PH_HDR_PIECE;
          if (s1_eof_q) begin
            rej_d = 1'b1;
          end
        end
        hfr_pkg::PH_HDR_PIECE: begin
          if (s1_char_q >= 8'h30 && s1_char_q < 8'(8'h30 + hfr_pkg::MaxPieces)) begin
            piece_d = 3'(s1_char_q - 8'h30);
          end else begin
            rej_d = 1'b1;
          end
          phase_d = hfr_pkg::PH_HDR_COUNT;
          if (s1_eof_q) begin
            rej_d = 1'b1;
          end
        end
        hfr_pkg::PH_HDR_COUNT: begin
          if (s1_char_q >= 8'h31 && s1_char_q <= 8'(8'h30 + hfr_pkg::MaxPieces)) begin
            total_d = 3'(s1_char_q - 8'h30);
            woff_d  = (start > 10'(BufLimit)) ? BufLimit : start[8:0];
          end else begin
            rej_d = 1'b1;
          end
          phase_d = hfr_pkg::PH_HIGH;
        end
        hfr_pkg::PH_HIGH: begin
          high_hex_d = hx.valid;
          high_nib_d = hx.valid ? hx.value : 4'd0;
          phase_d    = hfr_pkg::PH_LOW;
        end
        default: begin
          if (high_hex_q && hx.valid && woff_q < BufLimit) begin
            push_wr = 1'b1;
            woff_d  = woff_q + 9'd1;
          end
          high_hex_d = 1'b0;
          high_nib_d = 4'd0;
          phase_d    = hfr_pkg::PH_HIGH;
        end
      endcase
    end

    // Fragment status, built from the state as this character leaves it.
    st_res      = '0;
    st_res.last = 1'b1;
    if (rej_d) begin
      st_res.kind = hfr_pkg::KIND_REJECT;
    end else begin
      st_res.kind = ({1'b0, piece_d} + 4'd1 == {1'b0, total_d}) ?
                    hfr_pkg::KIND_COMPLETE : hfr_pkg::KIND_MORE;
      st_res.position     = (woff_d > BufLimit) ? BufLimit : woff_d;
      st_res.peer_type    = peer_d;
      st_res.sequence_res = seq_d;
    end
    push_st = s1_eof_q;

    if (s1_eof_q) begin
      phase_d    = hfr_pkg::PH_HDR_SEQ;
      high_nib_d = 4'd0;
      high_hex_d = 1'b0;
      rej_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q   <= hfr_pkg::StrideReset;
      s1_valid_q <= 1'b0;
      phase_q    <= hfr_pkg::PH_HDR_SEQ;
      high_nib_q <= '0;
      high_hex_q <= 1'b0;
      peer_q     <= 1'b0;
      seq_q      <= '0;
      piece_q    <= '0;
      total_q    <= '0;
      woff_q     <= '0;
      rej_q      <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        stride_q <= cfg_data_i;
      end
      s1_valid_q <= s1_valid_d;
      if (s1_advance) begin
        phase_q    <= phase_d;
        high_nib_q <= high_nib_d;
        high_hex_q <= high_hex_d;
        peer_q     <= peer_d;
        seq_q      <= seq_d;
        piece_q    <= piece_d;
        total_q    <= total_d;
        woff_q     <= woff_d;
        rej_q      <= rej_d;
        tail_q     <= tail_q + 2'({1'b0, push_wr} + {1'b0, push_st});
      end
      if (pop) begin
        head_q <= head_q + 2'd1;
      end
      count_q <= count_q
               + (s1_advance ? 3'({1'b0, push_wr} + {1'b0, push_st}) : 3'd0)
               - (pop ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_char_q <= char_in_i;
      s1_eof_q  <= end_of_fragment_i;
    end
    if (s1_advance) begin
      if (push_wr) begin
        fifo_q[tail_q] <= wr_res;
      end
      if (push_st) begin
        fifo_q[tail_q + 2'(push_wr)] <= st_res;
      end
    end
  end

  assign out_valid_o    = count_q != 3'd0;
  assign kind_o         = fifo_q[head_q].kind;
  assign data_byte_o    = fifo_q[head_q].data_byte;
  assign position_o     = fifo_q[head_q].position;
  assign peer_type_o    = fifo_q[head_q].peer_type;
  assign sequence_res_o = fifo_q[head_q].sequence_res;
  assign last_o         = fifo_q[head_q].last;

  `HFR_ASSERT_NEVER(a_queue_bound, count_q > 3'd4, "result queue over capacity")
  `HFR_ASSERT(a_status_last,
    out_valid_o && kind_o != hfr_pkg::KIND_WRITE |-> last_o, "status not last")
  `HFR_ASSERT(a_write_in_buf,
    out_valid_o && kind_o == hfr_pkg::KIND_WRITE |-> position_o < BufLimit,
    "write beyond buffer")
  `HFR_ASSERT(a_reject_clean,
    out_valid_o && kind_o == hfr_pkg::KIND_REJECT |->
      position_o == 9'd0 && !peer_type_o && sequence_res_o == 3'd0,
    "reject carries data")

endmodule
